>>> rtl/core/hvt_pkg.sv
package hvt_pkg;

    localparam int DIM      = 4;
    localparam int NCOEF    = DIM * DIM;
    localparam int IDX_W    = 4;
    localparam int VAL_W    = 32;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int PAIR_W   = PROD_W + 1;
    localparam int SUM_W    = PROD_W + 2;

    // stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = IDX_W + VAL_W + DIM * VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = DIM * VAL_W;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_op;

    typedef struct packed {
        t_op                           op;
        logic [IDX_W-1:0]              idx;
        logic [VAL_W-1:0]              coef;
        logic [DIM-1:0][VAL_W-1:0]     vec;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> rtl/core/hvt_front.sv
module hvt_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [hvt_pkg::S_TDATA_W-1:0]   i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hvt_pkg::t_item                  o_item
);
    import hvt_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;

    // unpack and classify; vector fields of a load and coefficient fields
    // of a transform are dropped here
    always_comb begin
        n_item      = '0;
        n_item.op   = t_op'(i_op);
        if (n_item.op == OP_LOAD) begin
            n_item.idx  = i_data[IDX_W-1:0];
            n_item.coef = i_data[IDX_W +: VAL_W];
        end else begin
            for (int c = 0; c < DIM; c++) begin
                n_item.vec[c] = i_data[IDX_W + VAL_W + c*VAL_W +: VAL_W];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/hvt_queue.sv
module hvt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hvt_pkg::t_item  i_item,
    output logic            o_push_ready,
    input  logic            i_pop,
    output logic            o_pop_valid,
    output hvt_pkg::t_item  o_item,
    output hvt_pkg::t_qstat o_stat
);
    import hvt_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           push_ok;
    logic           pop_ok;

    assign o_stat.full   = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty  = (r_cnt == '0);
    assign o_push_ready  = !o_stat.full;
    assign o_pop_valid   = !o_stat.empty;
    assign push_ok       = i_push && !o_stat.full;
    assign pop_ok        = i_pop && !o_stat.empty;
    assign o_item        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wr <= r_wr + 1'b1;
            if (pop_ok)  r_rd <= r_rd + 1'b1;
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/core/hvt_back.sv
module hvt_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  hvt_pkg::t_item                  i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [hvt_pkg::M_TDATA_W-1:0]   o_data,
    output logic                            o_sat
);
    import hvt_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);
    localparam logic [VAL_W-1:0]        ONE     = VAL_W'(1) << FRAC_BITS;

    logic [VAL_W-1:0]           r_matrix [DIM][DIM];
    logic signed [PROD_W-1:0]   r_prod   [DIM][DIM];
    logic signed [PAIR_W-1:0]   r_pair   [DIM][2];
    logic signed [SUM_W-1:0]    r_sum    [DIM];
    logic                       r_v1, r_v2, r_v3, r_vo;
    logic [M_TDATA_W-1:0]       r_out;
    logic                       r_sat;
    logic [M_TDATA_W-1:0]       n_out;
    logic                       n_sat;
    logic                       en;
    logic [1:0]                 wr_row;
    logic [1:0]                 wr_col;

    // whole pipe advances together whenever the output slot frees up
    assign en     = !r_vo || i_ready;
    assign o_pop  = i_valid && en;
    assign wr_row = i_item.idx[3:2];
    assign wr_col = i_item.idx[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_matrix[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (o_pop && i_item.op == OP_LOAD) begin
            r_matrix[wr_row][wr_col] <= i_item.coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid && (i_item.op == OP_XFORM);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    // stage 1: sixteen products, stage 2: pair sums, stage 3: row sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_prod[r][c] <= $signed(r_matrix[r][c]) * $signed(i_item.vec[c]);
                end
                r_pair[r][0] <= PAIR_W'(r_prod[r][0]) + PAIR_W'(r_prod[r][1]);
                r_pair[r][1] <= PAIR_W'(r_prod[r][2]) + PAIR_W'(r_prod[r][3]);
                r_sum[r]     <= SUM_W'(r_pair[r][0]) + SUM_W'(r_pair[r][1]);
            end
        end
    end

    // stage 4: rescale (floor) and clip
    always_comb begin
        logic signed [SUM_W-1:0] sh;
        n_out = '0;
        n_sat = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            sh = r_sum[r] >>> FRAC_BITS;
            if (sh > SAT_MAX) begin
                n_out[r*VAL_W +: VAL_W] = SAT_MAX[VAL_W-1:0];
                n_sat = 1'b1;
            end else if (sh < SAT_MIN) begin
                n_out[r*VAL_W +: VAL_W] = SAT_MIN[VAL_W-1:0];
                n_sat = 1'b1;
            end else begin
                n_out[r*VAL_W +: VAL_W] = sh[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_vo;
    assign o_data  = r_out;
    assign o_sat   = r_sat;

endmodule

>>> rtl/core/homogeneous_vertex_transform.sv
// Channel  | Dir | Fields (tdata / tuser, lowest bit first)
// s_axis   | in  | tdata: coef_index[3:0] coef_value[35:4] vec_x..vec_w[163:36], 0-pad to 168
//          |     | tuser: operation (0 load coefficient, 1 transform vector)
// m_axis   | out | tdata: out_x[31:0] out_y[63:32] out_z[95:64] out_w[127:96]
//          |     | tuser: saturated
//
// One transaction per clock sustained on both sides while m_axis tready stays high; a load gives no result.
// A transform passes from input acceptance through the front register, the queue,
// the product stage, two adder stages and the output register.
// Each clock's rate is set by the sixteen parallel 32x32 multipliers.
// Reset (synchronous, active low) loads the identity matrix and empties the queue.
// Input stalls only when the four-entry queue and front register are full;
// the back pipeline freezes as a whole while the output waits on tready.
module homogeneous_vertex_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [hvt_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,   // index, coef, x, y, z, w
    input  logic                            i_s_axis_tuser,   // operation
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [hvt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic                            o_m_axis_tuser    // saturated
);
    import hvt_pkg::*;

    logic   front_valid;
    logic   q_push_ready;
    t_item  front_item;
    logic   q_valid;
    logic   q_pop;
    t_item  q_item;
    t_qstat q_stat;

    // front: accept and sort each transaction into load / transform
    hvt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .o_valid (front_valid),
        .i_ready (q_push_ready),
        .o_item  (front_item)
    );

    // short queue so the input side keeps moving while the output stalls
    hvt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .i_item       (front_item),
        .o_push_ready (q_push_ready),
        .i_pop        (q_pop),
        .o_pop_valid  (q_valid),
        .o_item       (q_item),
        .o_stat       (q_stat)
    );

    // back: matrix store plus multiply / add / clip pipeline
    hvt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_sat   (o_m_axis_tuser)
    );

    // back never pulls from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // queue status is consistent
    a_stat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    // front holds its item while the queue is full
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && q_stat.full && !q_pop) |=> front_valid)
        else $error("front item lost while queue full");

endmodule

>>> sim/hvt_vertex_checker.sv
module hvt_vertex_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [hvt_pkg::S_TDATA_W-1:0] i_s_tdata,    // coef_index, coef_value, vec_x..vec_w
    input  logic                          i_s_tuser,    // operation
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [hvt_pkg::M_TDATA_W-1:0] i_m_tdata,    // out_x, out_y, out_z, out_w
    input  logic                          i_m_tuser,    // saturated
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hvt_pkg::*;

    typedef struct packed {
        logic                      sat;
        logic [DIM-1:0][VAL_W-1:0] comp;
    } t_vertex;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    logic signed [VAL_W-1:0] coef_mem [NCOEF];
    t_vertex                 expected_vertices [$];
    string                   axis_tag [DIM] = '{"x", "y", "z", "w"};

    // row times column vector: exact 66-bit sum, floor shift, clamp to 32 bits
    function automatic t_vertex transform_vertex(input logic [DIM-1:0][VAL_W-1:0] vec);
        t_vertex                 r;
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] scaled;
        r = '0;
        for (int row = 0; row < DIM; row++) begin
            acc = '0;
            for (int col = 0; col < DIM; col++)
                acc = acc + coef_mem[row * DIM + col] * $signed(vec[col]);
            scaled = acc >>> FRAC_BITS;
            if (scaled > SAT_HI) begin
                scaled = SAT_HI;
                r.sat  = 1'b1;
            end else if (scaled < SAT_LO) begin
                scaled = SAT_LO;
                r.sat  = 1'b1;
            end
            r.comp[row] = scaled[VAL_W-1:0];
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [VAL_W-1:0] want_v,
                                input logic [VAL_W-1:0] got_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t mismatch %s: expected %h got %h", $time, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        if (!i_rst_n) begin
            for (int k = 0; k < NCOEF; k++)
                coef_mem[k] = (k % (DIM + 1) == 0) ? (32'sd1 <<< FRAC_BITS) : '0;
            expected_vertices.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.comp = i_m_tdata;
                got.sat  = i_m_tuser;
                if (expected_vertices.size() == 0) begin
                    log_mismatch("unexpected result, out_x", '0, got.comp[0]);
                end else begin
                    want = expected_vertices.pop_front();
                    for (int c = 0; c < DIM; c++)
                        if (got.comp[c] !== want.comp[c])
                            log_mismatch({"out_", axis_tag[c]}, want.comp[c], got.comp[c]);
                    if (got.sat !== want.sat)
                        log_mismatch("saturated", VAL_W'(want.sat), VAL_W'(got.sat));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_op'(i_s_tuser) == OP_LOAD)
                    coef_mem[i_s_tdata[IDX_W-1:0]] = i_s_tdata[IDX_W +: VAL_W];
                else
                    expected_vertices.push_back(
                        transform_vertex(i_s_tdata[IDX_W + VAL_W +: DIM * VAL_W]));
            end
        end
        o_pending = expected_vertices.size();
    end

endmodule

>>> sim/homogeneous_vertex_transform_tb.sv
module homogeneous_vertex_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hvt_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 600;
    // receiver goes quiet once this many transactions are in, long enough to
    // fill the queue, the front register and the frozen back pipeline
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 120;
    // window of back-to-back traffic on both sides
    localparam int QUIET_FROM   = 320;
    localparam int QUIET_LEN    = 80;
    // leave some margin after the last result
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic [VAL_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] Q_ONE = 32'h0001_0000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // coef_index, coef_value, vec_x, vec_y, vec_z, vec_w
    logic                 s_tuser;     // operation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // out_x, out_y, out_z, out_w
    logic                 m_tuser;     // saturated

    int fail_count;
    int pending;
    int n_accepted = 0;
    bit no_idle    = 1'b0;

    // directed matrix: row 0 all most-negative, row 1 all most-positive so that
    // both clamp directions and the largest possible sum are reached; row 2
    // holds a raw -1 so a tiny negative sum must floor to -1; row 3 passes w
    logic [VAL_W-1:0] directed_coefs [NCOEF] = '{
        Q_MIN, Q_MIN, Q_MIN, Q_MIN,
        Q_MAX, Q_MAX, Q_MAX, Q_MAX,
        32'hffff_ffff, 32'h0001_8000, 32'h0000_0001, 32'hffff_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, Q_ONE
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    homogeneous_vertex_transform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    hvt_vertex_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle length in cycles: mostly none, some short, a few long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Q16.16 operand: extremes now and then, full-range noise, and mostly
    // modest magnitudes (+-16.0) so that clamping stays the exception
    function automatic logic [VAL_W-1:0] rand_fixed();
        int small_v;
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return $urandom();
            default: begin
                small_v = $urandom_range(0, 1 << 21);
                return VAL_W'(small_v - (1 << 20));
            end
        endcase
    endfunction

    // Drive one transaction at the falling edge, hold it until a rising edge
    // sees tready, then optionally leave a gap. With no gap tvalid stays high
    // and the next call just swaps the payload at the next falling edge.
    task automatic offer_item(input t_op op, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] coef,
                              input logic [DIM-1:0][VAL_W-1:0] vec);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[IDX_W-1:0]                = idx;
        word[IDX_W +: VAL_W]           = coef;
        word[IDX_W + VAL_W +: DIM * VAL_W] = vec;
        @(negedge clk);
        s_tdata  = word;
        s_tuser  = op;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        n_accepted++;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // vector fields ride along as noise; the block must ignore them on a load
    task automatic offer_load(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] coef);
        offer_item(OP_LOAD, idx, coef, {$urandom(), $urandom(), $urandom(), $urandom()});
    endtask

    // index and coefficient fields are noise on a transform
    task automatic offer_transform(input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                                   input logic [VAL_W-1:0] z, input logic [VAL_W-1:0] w);
        offer_item(OP_XFORM, IDX_W'($urandom()), $urandom(), {w, z, y, x});
    endtask

    // stimulus: reset, directed transactions, random bursts, drain, verdict
    initial begin
        int n_loads;
        int n_xf;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_LOAD;
        rst_n    = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // identity after reset passes the vector through, extremes included
        offer_transform(Q_ONE, 32'hfffd_8000, Q_MAX, Q_MIN);
        offer_transform('0, '0, '0, '0);

        // every coefficient position, in order
        for (int k = 0; k < NCOEF; k++)
            offer_load(IDX_W'(k), directed_coefs[k]);

        // all most-negative: row 0 sums to +2^64, row 1 clamps low
        offer_transform(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        // all most-positive: row 0 clamps low, row 1 clamps high
        offer_transform(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        // raw lsb in x only: row 2 gives -1 raw, floored rather than truncated
        offer_transform(32'h0000_0001, '0, '0, '0);
        // mixed signs without clamping on rows 2 and 3
        offer_transform(32'h0002_0000, 32'hffff_0000, 32'h0000_8000, 32'hffff_ffff);

        // random part: now and then a short burst of coefficient loads (sometimes a
        // full matrix rewrite), then a run of vertices through that matrix
        while (n_accepted < RANDOM_ITEMS + 2 * NCOEF) begin
            no_idle = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_FROM + QUIET_LEN);
            if ($urandom_range(0, 3) == 0) begin
                n_loads = ($urandom_range(0, 9) == 0) ? NCOEF : $urandom_range(1, 5);
                for (int k = 0; k < n_loads; k++)
                    offer_load((n_loads == NCOEF) ? IDX_W'(k) : IDX_W'($urandom()),
                               rand_fixed());
            end
            n_xf = $urandom_range(1, 10);
            for (int k = 0; k < n_xf; k++)
                offer_transform(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
        end
        no_idle = 1'b0;

        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off while the
    // sender keeps offering, which must back up into s_axis tready
    initial begin
        int gap;
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && n_accepted >= HOLD_AT) begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready = 1'b1;
            end else begin
                gap = no_idle ? 0 : idle_len();
                if (gap == 0) begin
                    m_tready = 1'b1;
                end else begin
                    m_tready = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    // hang guard
    initial begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
